[rtl/tspm_pkg.sv]
// ----------------------------------------------------------------------------
// tspm_pkg
// Shared types and constants of the tile slot pool manager.
// ----------------------------------------------------------------------------
package tspm_pkg;

   localparam int SLOTS_DEF   = 16;
   localparam int TILE_H_DEF  = 128;

   localparam int SLOT_IDX_W  = 6;    // covers up to 64 slots
   localparam int CNT_W       = 7;    // holds a slot count up to 64
   localparam int ACTIVE_W    = 5;
   localparam int BASE_W      = 24;
   localparam int RANGE_W     = 25;
   localparam int SEL_W       = 4;
   localparam int SLOT_OUT_W  = 4;
   localparam int CMD_W       = 3;
   localparam int STATUS_W    = 3;
   localparam int REQ_DATA_W  = 112;
   localparam int RSP_DATA_W  = 32;

   localparam logic [ACTIVE_W-1:0] ACTIVE_RST = 5'd16;

   typedef enum logic [CMD_W-1:0] {
      CMD_ACQUIRE     = 3'd0,
      CMD_FIND        = 3'd1,
      CMD_INV_ALL     = 3'd2,
      CMD_INV_RANGE   = 3'd3,
      CMD_EVICT_OUT   = 3'd4,
      CMD_EVICT_SLOT  = 3'd5,
      CMD_MARK_CLEAN  = 3'd6,
      CMD_CLEAR       = 3'd7
   } cmd_type;

   typedef enum logic [STATUS_W-1:0] {
      STS_HIT   = 3'd0,
      STS_FREE  = 3'd1,
      STS_EVICT = 3'd2,
      STS_NONE  = 3'd3,
      STS_DONE  = 3'd4
   } status_type;

   typedef enum logic [1:0] {
      FSM_IDLE,
      FSM_SCAN,
      FSM_EXEC
   } fsm_type;

   // running search result handed from cell to cell
   typedef struct packed {
      logic                   hit_found;
      logic [SLOT_IDX_W-1:0]  hit_idx;
      logic                   hit_dirty;
      logic                   free_found;
      logic [SLOT_IDX_W-1:0]  free_idx;
      logic                   best_found;
      logic [SLOT_IDX_W-1:0]  best_idx;
      logic [BASE_W-1:0]      best_dist;
      logic [BASE_W-1:0]      best_base;
   } scan_type;

   // request and commit controls broadcast to every cell
   typedef struct packed {
      logic                   commit;
      cmd_type                cmd;
      logic [BASE_W-1:0]      base;
      logic [RANGE_W-1:0]     top;
      logic [RANGE_W-1:0]     bot;
      logic [BASE_W-1:0]      scroll;
      logic [SEL_W-1:0]       sel;
      logic [CNT_W-1:0]       count;
      logic                   acq_we;
      logic [SLOT_IDX_W-1:0]  acq_idx;
   } ctl_type;

endpackage

[rtl/tspm_cell.sv]
// ----------------------------------------------------------------------------
// tspm_cell
// One pool slot: valid, base and dirty state, one search step per token,
// and the local update on commit.
// ----------------------------------------------------------------------------
module tspm_cell #(
   parameter int IDX    = 0,
   parameter int TILE_H = tspm_pkg::TILE_H_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  tspm_pkg::ctl_type  ctl,
   input  logic               token_in,
   input  tspm_pkg::scan_type scan_in,
   output logic               token_out,
   output tspm_pkg::scan_type scan_out
);

   localparam int XW = tspm_pkg::RANGE_W + 2;

   logic                          valid_ff, valid_in;
   logic                          dirty_ff, dirty_in;
   logic [tspm_pkg::BASE_W-1:0]   base_ff,  base_in;
   logic                          token_ff;
   tspm_pkg::scan_type            scan_ff,  scan_in_next;

   logic                          active;
   logic                          match;
   logic                          mine;
   logic [tspm_pkg::BASE_W:0]     diff;
   logic [tspm_pkg::BASE_W-1:0]   distance;
   logic signed [XW-1:0]          base_x, end_x, top_x, bot_x;
   logic                          overlap, outside;

   assign active  = tspm_pkg::CNT_W'(IDX) < ctl.count;
   assign match   = active && valid_ff && (base_ff == ctl.base);
   assign mine    = active && ({{(tspm_pkg::SLOT_IDX_W-tspm_pkg::SEL_W){1'b0}}, ctl.sel}
                    == tspm_pkg::SLOT_IDX_W'(IDX));

   assign diff     = {1'b0, base_ff} - {1'b0, ctl.scroll};
   assign distance = diff[tspm_pkg::BASE_W] ? (~diff[tspm_pkg::BASE_W-1:0] + 1'b1)
                                            : diff[tspm_pkg::BASE_W-1:0];

   assign base_x  = $signed({3'b000, base_ff});
   assign end_x   = base_x + $signed(XW'(TILE_H));
   assign top_x   = $signed({{2{ctl.top[tspm_pkg::RANGE_W-1]}}, ctl.top});
   assign bot_x   = $signed({{2{ctl.bot[tspm_pkg::RANGE_W-1]}}, ctl.bot});
   assign overlap = (end_x > top_x) && (base_x < bot_x);
   assign outside = (end_x <= top_x) || (base_x >= bot_x);

   always_comb begin
      scan_in_next = scan_in;
      if (active) begin
         if (match && !scan_in.hit_found) begin
            scan_in_next.hit_found = 1'b1;
            scan_in_next.hit_idx   = tspm_pkg::SLOT_IDX_W'(IDX);
            scan_in_next.hit_dirty = dirty_ff;
         end
         if (!valid_ff && !scan_in.free_found) begin
            scan_in_next.free_found = 1'b1;
            scan_in_next.free_idx   = tspm_pkg::SLOT_IDX_W'(IDX);
         end
         if (!scan_in.best_found || (distance > scan_in.best_dist)) begin
            scan_in_next.best_found = 1'b1;
            scan_in_next.best_idx   = tspm_pkg::SLOT_IDX_W'(IDX);
            scan_in_next.best_dist  = distance;
            scan_in_next.best_base  = base_ff;
         end
      end
   end

   always_comb begin
      valid_in = valid_ff;
      dirty_in = dirty_ff;
      base_in  = base_ff;
      if (ctl.commit) begin
         case (ctl.cmd)
            tspm_pkg::CMD_ACQUIRE: begin
               if (ctl.acq_we && (ctl.acq_idx == tspm_pkg::SLOT_IDX_W'(IDX))) begin
                  valid_in = 1'b1;
                  dirty_in = 1'b1;
                  base_in  = ctl.base;
               end
            end
            tspm_pkg::CMD_INV_ALL: begin
               if (active) dirty_in = 1'b1;
            end
            tspm_pkg::CMD_INV_RANGE: begin
               if (active && valid_ff && overlap) dirty_in = 1'b1;
            end
            tspm_pkg::CMD_EVICT_OUT: begin
               if (active && valid_ff && outside) begin
                  valid_in = 1'b0;
                  dirty_in = 1'b0;
               end
            end
            tspm_pkg::CMD_EVICT_SLOT: begin
               if (mine) begin
                  valid_in = 1'b0;
                  dirty_in = 1'b0;
               end
            end
            tspm_pkg::CMD_MARK_CLEAN: begin
               if (mine) dirty_in = 1'b0;
            end
            tspm_pkg::CMD_CLEAR: begin
               valid_in = 1'b0;
               dirty_in = 1'b0;
            end
            default: begin
               valid_in = valid_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         dirty_ff <= 1'b0;
         token_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         dirty_ff <= dirty_in;
         token_ff <= token_in;
      end
   end

   always_ff @(posedge clock) begin
      base_ff <= base_in;
      if (token_in) scan_ff <= scan_in_next;
   end

   assign token_out = token_ff;
   assign scan_out  = scan_ff;

endmodule

[rtl/tile_slot_pool_manager_unit.sv]
// ----------------------------------------------------------------------------
// tile_slot_pool_manager_unit
// Tile slot pool with lookup, free-slot allocation and farthest-base
// eviction, built as a chain of slot cells.
//
//   channel | ports                              | content
//   req     | req_tvalid req_tready req_tdata    | one command item
//   rsp     | rsp_tvalid rsp_tready rsp_tdata    | one result item per command
//   csr     | csr_valid csr_ready csr_data       | active_slots register
//
// Acquire and find (with a nonempty pool): a search token walks the cell chain
// one slot per cycle; when it leaves the last cell the sequencer moves to its
// commit state, and the next item is taken once the result is loaded.
// Other commands go straight from accept to the commit state; all cells
// update in parallel. One item in flight; a result waiting in the output
// register holds the next commit until taken. Reset empties the pool,
// active_slots = 16.
// ----------------------------------------------------------------------------
module tile_slot_pool_manager_unit #(
   parameter int SLOTS  = tspm_pkg::SLOTS_DEF,
   parameter int TILE_H = tspm_pkg::TILE_H_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // cmd[2:0] tile_base[26:3] range_top[51:27] range_bottom[76:52]
   // scroll_pos[100:77] slot_sel[104:101] zero[111:105]
   input  logic [tspm_pkg::REQ_DATA_W-1:0]     req_tdata,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // status[2:0] slot_out[6:3] slot_dirty[7] evicted_base[31:8]
   output logic [tspm_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [tspm_pkg::ACTIVE_W-1:0]       csr_data
);

   tspm_pkg::fsm_type                  state_ff, state_in;
   logic                               launch_ff, launch_in;
   logic [tspm_pkg::ACTIVE_W-1:0]      active_ff;
   tspm_pkg::cmd_type                  cmd_ff;
   logic [tspm_pkg::BASE_W-1:0]        base_ff, scroll_ff;
   logic [tspm_pkg::RANGE_W-1:0]       top_ff, bot_ff;
   logic [tspm_pkg::SEL_W-1:0]         sel_ff;
   logic                               rsp_valid_ff, rsp_valid_in;
   logic [tspm_pkg::RSP_DATA_W-1:0]    rsp_data_ff, rsp_data_in;

   logic                               accept;
   logic                               out_free;
   logic                               scan_cmd;
   logic                               commit;
   logic [tspm_pkg::CNT_W-1:0]         count;
   tspm_pkg::ctl_type                  ctl;
   tspm_pkg::scan_type                 last;
   tspm_pkg::status_type               status;
   logic [tspm_pkg::SLOT_IDX_W-1:0]    slot;
   logic                               dirty;
   logic [tspm_pkg::BASE_W-1:0]        old_base;
   logic                               acq_we;
   logic [tspm_pkg::SLOT_IDX_W-1:0]    acq_idx;

   logic                               tok [SLOTS+1];
   tspm_pkg::scan_type                 chain [SLOTS+1];
   logic [SLOTS:0]                     tok_vec;

   assign csr_ready = 1'b1;
   assign count = ({2'b00, active_ff} < tspm_pkg::CNT_W'(SLOTS)) ?
                  {2'b00, active_ff} : tspm_pkg::CNT_W'(SLOTS);

   assign req_tready = (state_ff == tspm_pkg::FSM_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign scan_cmd   = ((tspm_pkg::cmd_type'(req_tdata[2:0]) == tspm_pkg::CMD_ACQUIRE) ||
                        (tspm_pkg::cmd_type'(req_tdata[2:0]) == tspm_pkg::CMD_FIND)) &&
                       (count != '0);
   assign last = chain[SLOTS];

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         tspm_pkg::FSM_IDLE: begin
            if (accept) state_in = scan_cmd ? tspm_pkg::FSM_SCAN : tspm_pkg::FSM_EXEC;
         end
         tspm_pkg::FSM_SCAN: begin
            if (tok[SLOTS]) state_in = tspm_pkg::FSM_EXEC;
         end
         tspm_pkg::FSM_EXEC: begin
            if (out_free) state_in = tspm_pkg::FSM_IDLE;
         end
         default: state_in = tspm_pkg::FSM_IDLE;
      endcase
   end

   // outputs of the sequencer
   always_comb begin
      launch_in = accept && scan_cmd;
      commit    = (state_ff == tspm_pkg::FSM_EXEC) && out_free;
   end

   // result and acquire target
   always_comb begin
      status   = tspm_pkg::STS_DONE;
      slot     = '0;
      dirty    = 1'b0;
      old_base = '0;
      acq_we   = 1'b0;
      acq_idx  = '0;
      case (cmd_ff)
         tspm_pkg::CMD_ACQUIRE: begin
            if (count == '0) begin
               status = tspm_pkg::STS_NONE;
            end else if (last.hit_found) begin
               status = tspm_pkg::STS_HIT;
               slot   = last.hit_idx;
               dirty  = last.hit_dirty;
            end else if (last.free_found) begin
               status  = tspm_pkg::STS_FREE;
               slot    = last.free_idx;
               dirty   = 1'b1;
               acq_we  = 1'b1;
               acq_idx = last.free_idx;
            end else begin
               status   = tspm_pkg::STS_EVICT;
               slot     = last.best_idx;
               dirty    = 1'b1;
               old_base = last.best_base;
               acq_we   = 1'b1;
               acq_idx  = last.best_idx;
            end
         end
         tspm_pkg::CMD_FIND: begin
            if ((count != '0) && last.hit_found) begin
               status = tspm_pkg::STS_HIT;
               slot   = last.hit_idx;
               dirty  = last.hit_dirty;
            end else begin
               status = tspm_pkg::STS_NONE;
            end
         end
         default: status = tspm_pkg::STS_DONE;
      endcase
   end

   always_comb begin
      ctl.commit  = commit;
      ctl.cmd     = cmd_ff;
      ctl.base    = base_ff;
      ctl.top     = top_ff;
      ctl.bot     = bot_ff;
      ctl.scroll  = scroll_ff;
      ctl.sel     = sel_ff;
      ctl.count   = count;
      ctl.acq_we  = acq_we;
      ctl.acq_idx = acq_idx;
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (rsp_valid_ff && rsp_tready) rsp_valid_in = 1'b0;
      if (commit) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = {old_base, dirty, slot[tspm_pkg::SLOT_OUT_W-1:0], status};
      end
   end

   assign tok[0]   = launch_ff;
   assign chain[0] = '0;

   for (genvar i = 0; i < SLOTS; i++) begin : g_cell
      tspm_cell #(
         .IDX    (i),
         .TILE_H (TILE_H)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .ctl       (ctl),
         .token_in  (tok[i]),
         .scan_in   (chain[i]),
         .token_out (tok[i+1]),
         .scan_out  (chain[i+1])
      );
   end

   for (genvar i = 0; i <= SLOTS; i++) begin : g_tok
      assign tok_vec[i] = tok[i];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= tspm_pkg::FSM_IDLE;
         launch_ff    <= 1'b0;
         active_ff    <= tspm_pkg::ACTIVE_RST;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         launch_ff    <= launch_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) active_ff <= csr_data;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      if (accept) begin
         cmd_ff    <= tspm_pkg::cmd_type'(req_tdata[2:0]);
         base_ff   <= req_tdata[26:3];
         top_ff    <= req_tdata[51:27];
         bot_ff    <= req_tdata[76:52];
         scroll_ff <= req_tdata[100:77];
         sel_ff    <= req_tdata[104:101];
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

`ifndef SYNTHESIS
   a_one_token: assert property (@(posedge clock) disable iff (reset)
      $onehot0(tok_vec))
      else $error("more than one search token in the cell chain");

   a_idle_no_token: assert property (@(posedge clock) disable iff (reset)
      (state_ff == tspm_pkg::FSM_IDLE) |-> (tok_vec == '0))
      else $error("search token alive while idle");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      accept |=> !req_tready)
      else $error("new item accepted while one is in flight");

   a_commit_loads_rsp: assert property (@(posedge clock) disable iff (reset)
      commit |=> rsp_valid_ff)
      else $error("commit without a result item");
`endif

endmodule

[tb/slot_pool_checker.sv]
// ----------------------------------------------------------------------------
// slot_pool_checker
// Watches the request, result and register channels of the tile slot pool
// manager. Keeps its own copy of the slot table and the active slot count,
// works out the result of every accepted request, and compares each
// accepted result field by field with the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module slot_pool_checker (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   input  logic                              req_tready,
   input  logic [tspm_pkg::REQ_DATA_W-1:0]   req_tdata,
   input  logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   input  logic [tspm_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   input  logic                              csr_valid,
   input  logic                              csr_ready,
   input  logic [tspm_pkg::ACTIVE_W-1:0]     csr_data,
   output int                                failures,
   output int                                outstanding
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int POOL_SLOTS = tspm_pkg::SLOTS_DEF;
   localparam longint TILE_ROWS = tspm_pkg::TILE_H_DEF;

   typedef struct packed {
      tspm_pkg::status_type         status;
      logic [3:0]                   slot;
      logic                         dirty;
      logic [tspm_pkg::BASE_W-1:0]  old_base;
   } pool_result_type;

   logic                          slot_live  [POOL_SLOTS];
   logic [tspm_pkg::BASE_W-1:0]   slot_y     [POOL_SLOTS];
   logic                          slot_stale [POOL_SLOTS];
   logic [tspm_pkg::ACTIVE_W-1:0] active_cfg;

   pool_result_type expected_q[$];

   task automatic reset_pool();
      for (int i = 0; i < POOL_SLOTS; i++) begin
         slot_live[i]  = 1'b0;
         slot_y[i]     = '0;
         slot_stale[i] = 1'b0;
      end
      active_cfg = tspm_pkg::ACTIVE_RST;
   endtask

   task automatic predict_command(input logic [tspm_pkg::REQ_DATA_W-1:0] d,
                                  output pool_result_type r);
      tspm_pkg::cmd_type                   op;
      logic [tspm_pkg::BASE_W-1:0]         base;
      logic signed [tspm_pkg::RANGE_W-1:0] top_s;
      logic signed [tspm_pkg::RANGE_W-1:0] bot_s;
      logic [tspm_pkg::BASE_W-1:0]         scroll;
      logic [tspm_pkg::SEL_W-1:0]          sel;
      longint                  top_l;
      longint                  bot_l;
      longint                  b;
      longint                  distance;
      longint                  best;
      int                      n;
      int                      hit;
      int                      free_idx;
      int                      idx;
      op     = tspm_pkg::cmd_type'(d[2:0]);
      base   = d[26:3];
      top_s  = d[51:27];
      bot_s  = d[76:52];
      scroll = d[100:77];
      sel    = d[104:101];
      top_l  = top_s;
      bot_l  = bot_s;
      n      = (int'(active_cfg) > POOL_SLOTS) ? POOL_SLOTS : int'(active_cfg);
      r      = '0;
      r.status = tspm_pkg::STS_DONE;
      hit = -1;
      for (int i = 0; i < n; i++)
         if (hit < 0 && slot_live[i] && slot_y[i] == base) hit = i;
      case (op)
         tspm_pkg::CMD_ACQUIRE: begin
            if (n == 0) begin
               r.status = tspm_pkg::STS_NONE;
            end else begin
               idx = 0;
               if (hit >= 0) begin
                  r.status = tspm_pkg::STS_HIT;
                  idx = hit;
               end else begin
                  free_idx = -1;
                  for (int i = 0; i < n; i++)
                     if (free_idx < 0 && !slot_live[i]) free_idx = i;
                  if (free_idx >= 0) begin
                     r.status = tspm_pkg::STS_FREE;
                     idx = free_idx;
                  end else begin
                     // farthest base from the scroll position, lowest index on ties
                     best = -1;
                     for (int i = 0; i < n; i++) begin
                        distance = longint'(slot_y[i]) - longint'(scroll);
                        if (distance < 0) distance = -distance;
                        if (distance > best) begin
                           best = distance;
                           idx = i;
                        end
                     end
                     r.status = tspm_pkg::STS_EVICT;
                     r.old_base = slot_y[idx];
                  end
                  slot_live[idx]  = 1'b1;
                  slot_y[idx]     = base;
                  slot_stale[idx] = 1'b1;
               end
               r.slot  = idx[3:0];
               r.dirty = slot_stale[idx];
            end
         end
         tspm_pkg::CMD_FIND: begin
            if (hit >= 0) begin
               r.status = tspm_pkg::STS_HIT;
               r.slot   = hit[3:0];
               r.dirty  = slot_stale[hit];
            end else begin
               r.status = tspm_pkg::STS_NONE;
            end
         end
         tspm_pkg::CMD_INV_ALL: begin
            for (int i = 0; i < n; i++) slot_stale[i] = 1'b1;
         end
         tspm_pkg::CMD_INV_RANGE: begin
            for (int i = 0; i < n; i++) begin
               b = longint'(slot_y[i]);
               if (slot_live[i] && b + TILE_ROWS > top_l && b < bot_l) slot_stale[i] = 1'b1;
            end
         end
         tspm_pkg::CMD_EVICT_OUT: begin
            for (int i = 0; i < n; i++) begin
               b = longint'(slot_y[i]);
               if (slot_live[i] && (b + TILE_ROWS <= top_l || b >= bot_l)) begin
                  slot_live[i]  = 1'b0;
                  slot_stale[i] = 1'b0;
               end
            end
         end
         tspm_pkg::CMD_EVICT_SLOT: begin
            if (int'(sel) < n) begin
               slot_live[sel]  = 1'b0;
               slot_stale[sel] = 1'b0;
            end
         end
         tspm_pkg::CMD_MARK_CLEAN: begin
            if (int'(sel) < n) slot_stale[sel] = 1'b0;
         end
         default: begin
            for (int i = 0; i < POOL_SLOTS; i++) begin
               slot_live[i]  = 1'b0;
               slot_stale[i] = 1'b0;
            end
         end
      endcase
   endtask

   always @(posedge clock) begin
      pool_result_type want;
      pool_result_type got;
      if (reset) begin
         reset_pool();
         expected_q.delete();
         failures <= 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got.status   = tspm_pkg::status_type'(rsp_tdata[2:0]);
            got.slot     = rsp_tdata[6:3];
            got.dirty    = rsp_tdata[7];
            got.old_base = rsp_tdata[31:8];
            if (expected_q.size() == 0) begin
               $display("%0t: unexpected result status=%0d slot=%0d dirty=%0d old=%h",
                        $time, got.status, got.slot, got.dirty, got.old_base);
               failures <= failures + 1;
            end else begin
               want = expected_q.pop_front();
               if (got.status !== want.status || got.slot !== want.slot ||
                   got.dirty !== want.dirty || got.old_base !== want.old_base) begin
                  $display({"%0t: expected status=%0d slot=%0d dirty=%0d old=%h,",
                            " got status=%0d slot=%0d dirty=%0d old=%h"},
                           $time, want.status, want.slot, want.dirty, want.old_base,
                           got.status, got.slot, got.dirty, got.old_base);
                  failures <= failures + 1;
               end
            end
         end
         if (csr_valid && csr_ready) active_cfg = csr_data;
         if (req_tvalid && req_tready) begin
            predict_command(req_tdata, want);
            expected_q.push_back(want);
         end
      end
      outstanding <= expected_q.size();
   end

endmodule

[tb/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// Drives the tile slot pool manager with a directed set of commands covering
// eviction ties, empty and saturated pools and out-of-range selects, then
// with random scroll-driven request streams under several active slot
// counts and handshake stall patterns. A separate checker predicts and
// compares every result.
// ----------------------------------------------------------------------------
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int MAX_Y = 24'hFFFFFF;
   localparam int MIN_RANGE = -16777216;
   localparam int MAX_RANGE = 16777215;
   localparam logic [tspm_pkg::RANGE_W-1:0] RANGE_LO = tspm_pkg::RANGE_W'(MIN_RANGE);
   localparam logic [tspm_pkg::RANGE_W-1:0] RANGE_HI = tspm_pkg::RANGE_W'(MAX_RANGE);

   logic                            clock = 1'b0;
   logic                            reset = 1'b1;
   logic                            req_tvalid = 1'b0;
   logic                            req_tready;
   logic [tspm_pkg::REQ_DATA_W-1:0] req_tdata = '0;
   logic                            rsp_tvalid;
   logic                            rsp_tready = 1'b0;
   logic [tspm_pkg::RSP_DATA_W-1:0] rsp_tdata;
   logic                            csr_valid = 1'b0;
   logic                            csr_ready;
   logic [tspm_pkg::ACTIVE_W-1:0]   csr_data = '0;

   int failures;
   int outstanding;
   int req_gap_pct = 21;
   int rsp_stall_pct = 69;
   int view_y;

   tile_slot_pool_manager_unit DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   slot_pool_checker pool_check (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_data    (csr_data),
      .failures    (failures),
      .outstanding (outstanding)
   );

   always #6 clock = ~clock;

   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(0, 99) >= rsp_stall_pct);
   end

   initial begin
      #5_000_000;
      $display("tile_slot_pool_manager_unit: mismatch");
      $finish;
   end

   function automatic int clamp(input int v, input int lo, input int hi);
      return (v < lo) ? lo : (v > hi) ? hi : v;
   endfunction

   task automatic send_request(input tspm_pkg::cmd_type op,
                               input logic [tspm_pkg::BASE_W-1:0] base,
                               input logic [tspm_pkg::RANGE_W-1:0] top,
                               input logic [tspm_pkg::RANGE_W-1:0] bot,
                               input logic [tspm_pkg::BASE_W-1:0] scroll,
                               input logic [tspm_pkg::SEL_W-1:0] sel);
      while ($urandom_range(0, 99) < req_gap_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {7'b0, sel, scroll, bot, top, base, op};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   // hold off new items until every result is back
   task automatic drain_pool();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
   endtask

   task automatic set_active(input logic [tspm_pkg::ACTIVE_W-1:0] value);
      drain_pool();
      csr_valid <= 1'b1;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic send_random_item();
      int pick;
      int top_i;
      int bot_i;
      int base_i;
      tspm_pkg::cmd_type op;
      logic [tspm_pkg::BASE_W-1:0] base;
      logic [tspm_pkg::BASE_W-1:0] scroll;
      logic [tspm_pkg::RANGE_W-1:0] top;
      logic [tspm_pkg::RANGE_W-1:0] bot;
      logic [tspm_pkg::SEL_W-1:0] sel;
      if ($urandom_range(0, 99) == 0)
         view_y = $urandom_range(0, 1) ? MAX_Y - int'($urandom_range(0, 600))
                                       : int'($urandom_range(0, 600));
      else
         view_y = clamp(view_y + int'($urandom_range(0, 256)) - 128, 0, MAX_Y);
      scroll = tspm_pkg::BASE_W'(view_y);
      base_i = (view_y / tspm_pkg::TILE_H_DEF + int'($urandom_range(0, 12)) - 6)
               * tspm_pkg::TILE_H_DEF;
      base   = tspm_pkg::BASE_W'(clamp(base_i, 0, MAX_Y));
      top_i  = view_y - int'($urandom_range(0, 768));
      bot_i  = clamp(view_y + int'($urandom_range(0, 768)), MIN_RANGE, MAX_RANGE);
      top    = tspm_pkg::RANGE_W'(top_i);
      bot    = tspm_pkg::RANGE_W'(bot_i);
      sel    = tspm_pkg::SEL_W'($urandom);
      pick   = int'($urandom_range(0, 99));
      // noise: anything goes
      if (pick < 10) begin
         op     = tspm_pkg::cmd_type'($urandom_range(0, 7));
         base   = tspm_pkg::BASE_W'($urandom);
         scroll = tspm_pkg::BASE_W'($urandom);
         top    = tspm_pkg::RANGE_W'($urandom);
         bot    = tspm_pkg::RANGE_W'($urandom);
      end else if (pick < 55) op = tspm_pkg::CMD_ACQUIRE;
      else if (pick < 72) op = tspm_pkg::CMD_FIND;
      else if (pick < 82) op = tspm_pkg::CMD_MARK_CLEAN;
      else if (pick < 87) op = tspm_pkg::CMD_INV_RANGE;
      else if (pick < 92) op = tspm_pkg::CMD_EVICT_OUT;
      else if (pick < 96) op = tspm_pkg::CMD_EVICT_SLOT;
      else if (pick < 98) op = tspm_pkg::CMD_INV_ALL;
      else op = tspm_pkg::CMD_CLEAR;
      send_request(op, base, top, bot, scroll, sel);
   endtask

   task automatic send_random(input int count);
      repeat (count) send_random_item();
   endtask

   initial begin
      view_y = int'($urandom_range(0, MAX_Y));
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // three slots: fill, tie on eviction, hits and misses
      set_active(5'd3);
      send_request(tspm_pkg::CMD_ACQUIRE,    24'h000100, '0, '0, 24'h000200, 4'd0);
      send_request(tspm_pkg::CMD_ACQUIRE,    24'h000300, '0, '0, 24'h000200, 4'd0);
      send_request(tspm_pkg::CMD_ACQUIRE,    24'h000200, '0, '0, 24'h000200, 4'd0);
      send_request(tspm_pkg::CMD_ACQUIRE,    24'h000500, '0, '0, 24'h000200, 4'd0);
      send_request(tspm_pkg::CMD_FIND,       24'h000300, '0, '0, 24'h000000, 4'd0);
      send_request(tspm_pkg::CMD_FIND,       24'h000100, '0, '0, 24'h000000, 4'd0);
      send_request(tspm_pkg::CMD_MARK_CLEAN, 24'h000000, '0, '0, 24'h000000, 4'd1);
      send_request(tspm_pkg::CMD_FIND,       24'h000300, '0, '0, 24'h000000, 4'd0);
      send_request(tspm_pkg::CMD_MARK_CLEAN, 24'h000000, '0, '0, 24'h000000, 4'd3);
      send_request(tspm_pkg::CMD_EVICT_SLOT, 24'h000000, '0, '0, 24'h000000, 4'd15);
      send_request(tspm_pkg::CMD_INV_ALL,    24'h000000, '0, '0, 24'h000000, 4'd0);
      send_request(tspm_pkg::CMD_MARK_CLEAN, 24'h000000, '0, '0, 24'h000000, 4'd0);
      send_request(tspm_pkg::CMD_INV_RANGE,  24'h000000, RANGE_LO, RANGE_HI, 24'h000000, 4'd0);
      send_request(tspm_pkg::CMD_INV_RANGE,  24'h000000, RANGE_HI, RANGE_LO, 24'h000000, 4'd0);
      send_request(tspm_pkg::CMD_EVICT_SLOT, 24'h000000, '0, '0, 24'h000000, 4'd1);
      send_request(tspm_pkg::CMD_MARK_CLEAN, 24'h000000, '0, '0, 24'h000000, 4'd1);
      send_request(tspm_pkg::CMD_ACQUIRE,    24'h000000, '0, '0, 24'hFFFFFF, 4'd0);
      send_request(tspm_pkg::CMD_ACQUIRE,    24'hFFFFFF, '0, '0, 24'h000000, 4'd0);
      send_request(tspm_pkg::CMD_EVICT_OUT,  24'h000000, RANGE_HI, RANGE_LO, 24'h000000, 4'd0);
      send_request(tspm_pkg::CMD_CLEAR,      24'h000000, '0, '0, 24'h000000, 4'd0);

      // empty pool
      set_active(5'd0);
      send_request(tspm_pkg::CMD_ACQUIRE,    24'h000040, '0, '0, 24'h000000, 4'd0);
      send_request(tspm_pkg::CMD_FIND,       24'h000040, '0, '0, 24'h000000, 4'd0);
      send_request(tspm_pkg::CMD_INV_ALL,    24'h000000, '0, '0, 24'h000000, 4'd0);
      send_request(tspm_pkg::CMD_INV_RANGE,  24'h000000, RANGE_LO, RANGE_HI, 24'h000000, 4'd0);
      send_request(tspm_pkg::CMD_EVICT_OUT,  24'h000000, RANGE_HI, RANGE_LO, 24'h000000, 4'd0);
      send_request(tspm_pkg::CMD_EVICT_SLOT, 24'h000000, '0, '0, 24'h000000, 4'd0);
      send_request(tspm_pkg::CMD_MARK_CLEAN, 24'h000000, '0, '0, 24'h000000, 4'd0);
      send_request(tspm_pkg::CMD_CLEAR,      24'h000000, '0, '0, 24'h000000, 4'd0);

      // saturating count, then small pools, then full rate
      set_active(5'd31);
      send_random(100);
      drain_pool();
      send_random(80);

      req_gap_pct = 69;
      rsp_stall_pct = 21;
      set_active(5'd1);
      send_random(90);
      set_active(5'd5);
      send_random(90);

      req_gap_pct = 0;
      rsp_stall_pct = 0;
      set_active(5'd16);
      send_random(100);
      set_active(5'd9);
      send_random(90);

      drain_pool();
      repeat (tspm_pkg::SLOTS_DEF + 8) @(posedge clock);
      if (failures == 0) begin
         $display("tile_slot_pool_manager_unit: match");
      end else begin
         $display("tile_slot_pool_manager_unit: mismatch");
      end
      $finish;
   end

endmodule

[filelist.f]
rtl/tspm_pkg.sv
rtl/tspm_cell.sv
rtl/tile_slot_pool_manager_unit.sv
tb/slot_pool_checker.sv
tb/testbench.sv
